### src/assert_macros.svh
// assertion helpers used by multi_term_line_match_counter
// clock and reset are the block's usual clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER_CLK(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");

`endif

### src/mtlm_pkg.sv
// ----------------------------------------------------------------------------
// mtlm_pkg
// shared types, constants and helpers of the multi-term line match counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtlm_pkg;

  localparam int unsigned TERM_SLOTS_DEF     = 4;
  localparam int unsigned MAX_TERM_BYTES_DEF = 8;

  localparam int unsigned LEN_W        = 4;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned LINE_SUM_W   = 16;
  localparam int unsigned COUNT_W      = 32;

  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QUEUE_CNT_W  = 3;
  localparam int unsigned QUEUE_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TERM_A  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTHS = 3'd4;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h00;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef enum logic {
    KIND_LINE    = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_e;

  typedef struct packed {
    result_kind_e        kind;
    logic [COUNT_W-1:0]  line_number;
    logic [COUNT_W-1:0]  match_count;
    logic                saw_zero;
    logic                last;
  } result_t;

  // up to two results written into the queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/mtlm_slot_matcher.sv
// ----------------------------------------------------------------------------
// mtlm_slot_matcher
// one search term: window compare and post-hit skip counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtlm_slot_matcher #(
  parameter int unsigned MaxTermBytes = mtlm_pkg::MAX_TERM_BYTES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  logic                                 content_i,
  input  logic                                 line_end_i,
  input  logic [MaxTermBytes-1:0][7:0]         window_i,
  input  logic [$clog2(MaxTermBytes+1)-1:0]    fill_i,
  input  logic [MaxTermBytes*8-1:0]            term_i,
  input  logic [mtlm_pkg::LEN_W-1:0]           len_i,
  output logic                                 hit_o
);

  localparam int unsigned SkipW = (MaxTermBytes > 1) ? $clog2(MaxTermBytes) : 1;
  localparam int unsigned AgeW  = (MaxTermBytes > 1) ? $clog2(MaxTermBytes) : 1;

  logic [mtlm_pkg::LEN_W-1:0] len_c;
  logic                       chars_ok;
  logic [SkipW-1:0]           skip_q, skip_d;

  assign len_c = (len_i > mtlm_pkg::LEN_W'(MaxTermBytes)) ?
                 mtlm_pkg::LEN_W'(MaxTermBytes) : len_i;

  // term byte k sits len-1-k bytes back from the newest one
  always_comb begin
    logic [mtlm_pkg::LEN_W-1:0] age;
    age      = '0;
    chars_ok = 1'b1;
    for (int k = 0; k < MaxTermBytes; k++) begin
      if (mtlm_pkg::LEN_W'(k) < len_c) begin
        age = len_c - mtlm_pkg::LEN_W'(k) - mtlm_pkg::LEN_W'(1);
        if (window_i[age[AgeW-1:0]] != mtlm_pkg::fold_byte(term_i[8*k +: 8])) begin
          chars_ok = 1'b0;
        end
      end
    end
  end

  assign hit_o = content_i && (skip_q == '0) && (len_c != '0) &&
                 (mtlm_pkg::LEN_W'(fill_i) >= len_c) && chars_ok;

  always_comb begin
    skip_d = skip_q;
    if (content_i) begin
      if (skip_q != '0) begin
        skip_d = skip_q - SkipW'(1);
      end else if (hit_o) begin
        skip_d = SkipW'(len_c - mtlm_pkg::LEN_W'(1));
      end
    end
    if (line_end_i) begin
      skip_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= '0;
    end else if (step_i) begin
      skip_q <= skip_d;
    end
  end

endmodule

`default_nettype wire

### src/mtlm_result_queue.sv
// ----------------------------------------------------------------------------
// mtlm_result_queue
// four-entry result queue, head at entry 0, up to two writes per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtlm_result_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mtlm_pkg::push_t   push_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mtlm_pkg::result_t out_data_o
);

  mtlm_pkg::result_t [mtlm_pkg::QUEUE_DEPTH-1:0] ent_q, ent_d;
  logic [mtlm_pkg::QUEUE_CNT_W-1:0] count_q, count_d, base;
  logic pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // room for two more results even without a pop
  assign space_o     = (count_q <= mtlm_pkg::QUEUE_CNT_W'(mtlm_pkg::QUEUE_DEPTH - 2));

  assign base    = count_q - mtlm_pkg::QUEUE_CNT_W'(pop);
  assign count_d = base + mtlm_pkg::QUEUE_CNT_W'(push_i.cnt);

  always_comb begin
    ent_d = ent_q;
    if (pop) begin
      for (int i = 0; i < mtlm_pkg::QUEUE_DEPTH - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end
    if (push_i.cnt != 2'd0) begin
      ent_d[base[mtlm_pkg::QUEUE_IDX_W-1:0]] = push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      ent_d[base[mtlm_pkg::QUEUE_IDX_W-1:0] + mtlm_pkg::QUEUE_IDX_W'(1)] = push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

### src/multi_term_line_match_counter.sv
// ----------------------------------------------------------------------------
// multi_term_line_match_counter
// case-insensitive multi-term match counter with per-line reports and a
// per-file summary
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_ready_o   content_byte_i, end_of_content_i
//  out       source     out_valid_o / out_ready_i result_kind_o .. last_of_run_o
//  cfg       sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
//  one byte per cycle while the result queue has room; an accepted byte waits in the
//  input register, and its results are written into the result queue as it leaves
//  the input register advances while the result queue has room for two
//  results; it stalls only when three or more results wait to be taken
//  each byte yields zero, one or two results (line report, file summary)
//  async active-low reset clears terms, counters, history and the queue
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module multi_term_line_match_counter #(
  parameter int unsigned TermSlots    = mtlm_pkg::TERM_SLOTS_DEF,
  parameter int unsigned MaxTermBytes = mtlm_pkg::MAX_TERM_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // content input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          content_byte_i,
  input  logic                                end_of_content_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                result_kind_o,
  output logic [mtlm_pkg::COUNT_W-1:0]        line_number_o,
  output logic [mtlm_pkg::COUNT_W-1:0]        match_count_o,
  output logic                                saw_zero_byte_o,
  output logic                                last_of_run_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [mtlm_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [mtlm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned FillW = $clog2(MaxTermBytes + 1);
  localparam int unsigned HitW  = $clog2(TermSlots + 1);

  // configuration registers
  logic [TermSlots-1:0][MaxTermBytes*8-1:0]   term_q;
  logic [TermSlots*mtlm_pkg::LEN_W-1:0]       len_q;

  // input register
  logic       in_v_q;
  logic [7:0] byte_q;
  logic       end_q;

  // file and line state
  logic [MaxTermBytes-1:0][7:0]        recent_q, recent_d;
  logic [FillW-1:0]                    fill_q, fill_d;
  logic [mtlm_pkg::LINE_SUM_W-1:0]     line_sum_q, line_sum_d;
  logic [mtlm_pkg::COUNT_W-1:0]        total_q, total_d;
  logic [mtlm_pkg::COUNT_W-1:0]        line_q, line_num;
  logic                                zero_q, zero_d;

  logic                       step;
  logic                       space;
  logic [7:0]                 folded;
  logic                       is_newline;
  logic                       is_content;
  logic                       line_end;
  logic [TermSlots-1:0]       slot_hit;
  logic [HitW-1:0]            hits;
  logic [mtlm_pkg::LINE_SUM_W:0] line_sum_ext;
  logic [mtlm_pkg::COUNT_W:0]    total_ext;
  logic                       report;

  mtlm_pkg::push_t   push;
  mtlm_pkg::result_t line_res, sum_res, head;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= '0;
      len_q  <= '0;
    end else if (cfg_we_i) begin
      for (int s = 0; s < TermSlots; s++) begin
        if (cfg_index_i == mtlm_pkg::CFG_TERM_A + mtlm_pkg::CFG_INDEX_W'(s)) begin
          term_q[s] <= cfg_data_i[MaxTermBytes*8-1:0];
        end
      end
      if (cfg_index_i == mtlm_pkg::CFG_LENGTHS) begin
        len_q <= cfg_data_i[TermSlots*mtlm_pkg::LEN_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------- input register
  // a transaction moves into the register whenever it is empty or the held one goes forward
  assign step       = in_v_q && space;
  assign in_ready_o = !in_v_q || space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= content_byte_i;
      end_q  <= end_of_content_i;
    end
  end

  // ------------------------------------------------------------ byte decode
  assign folded     = mtlm_pkg::fold_byte(byte_q);
  assign is_newline = (folded == mtlm_pkg::CHAR_NEWLINE);
  assign is_content = !is_newline;
  assign line_end   = is_newline || end_q;

  // history with the new byte at age zero; fill counts bytes of this line, up to MaxTermBytes
  always_comb begin
    recent_d[0] = folded;
    for (int a = 1; a < MaxTermBytes; a++) begin
      recent_d[a] = recent_q[a-1];
    end
  end

  assign fill_d = (fill_q == FillW'(MaxTermBytes)) ? fill_q : fill_q + FillW'(1);

  // ------------------------------------------------------------ term slots
  for (genvar s = 0; s < TermSlots; s++) begin : g_slot
    mtlm_slot_matcher #(
      .MaxTermBytes(MaxTermBytes)
    ) u_slot (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (step),
      .content_i  (is_content),
      .line_end_i (line_end),
      .window_i   (recent_d),
      .fill_i     (fill_d),
      .term_i     (term_q[s]),
      .len_i      (len_q[mtlm_pkg::LEN_W*s +: mtlm_pkg::LEN_W]),
      .hit_o      (slot_hit[s])
    );
  end

  always_comb begin
    hits = '0;
    for (int s = 0; s < TermSlots; s++) begin
      hits = hits + HitW'(slot_hit[s]);
    end
  end

  // ------------------------------------------------------ saturating counts
  // hits are zero on a newline byte, so no gating is needed
  assign line_sum_ext = (mtlm_pkg::LINE_SUM_W+1)'(line_sum_q) + (mtlm_pkg::LINE_SUM_W+1)'(hits);
  assign line_sum_d   = line_sum_ext[mtlm_pkg::LINE_SUM_W] ? '1 :
                        line_sum_ext[mtlm_pkg::LINE_SUM_W-1:0];
  assign total_ext    = (mtlm_pkg::COUNT_W+1)'(total_q) + (mtlm_pkg::COUNT_W+1)'(hits);
  assign total_d      = total_ext[mtlm_pkg::COUNT_W] ? '1 : total_ext[mtlm_pkg::COUNT_W-1:0];

  assign line_num = (line_q == '1) ? line_q : line_q + mtlm_pkg::COUNT_W'(1);
  assign zero_d   = zero_q || (byte_q == mtlm_pkg::CHAR_ZERO);

  // --------------------------------------------------------------- results
  assign report = line_end && (line_sum_d != '0);

  always_comb begin
    line_res.kind        = mtlm_pkg::KIND_LINE;
    line_res.line_number = line_num;
    line_res.match_count = mtlm_pkg::COUNT_W'(line_sum_d);
    line_res.saw_zero    = 1'b0;
    line_res.last        = !end_q;

    sum_res.kind        = mtlm_pkg::KIND_SUMMARY;
    sum_res.line_number = line_num;
    sum_res.match_count = total_d;
    sum_res.saw_zero    = zero_d;
    sum_res.last        = 1'b1;

    push.cnt    = 2'd0;
    push.first  = sum_res;
    push.second = sum_res;
    if (step) begin
      if (report) begin
        push.first = line_res;
        push.cnt   = end_q ? 2'd2 : 2'd1;
      end else if (end_q) begin
        push.cnt = 2'd1;
      end
    end
  end

  // ------------------------------------------------------------ state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q   <= '0;
      fill_q     <= '0;
      line_sum_q <= '0;
      total_q    <= '0;
      line_q     <= '0;
      zero_q     <= 1'b0;
    end else if (step) begin
      if (end_q) begin
        // file done: back to the reset picture
        recent_q   <= '0;
        fill_q     <= '0;
        line_sum_q <= '0;
        total_q    <= '0;
        line_q     <= '0;
        zero_q     <= 1'b0;
      end else if (is_newline) begin
        fill_q     <= '0;
        line_sum_q <= '0;
        line_q     <= line_num;
        zero_q     <= zero_d;
      end else begin
        recent_q   <= recent_d;
        fill_q     <= fill_d;
        line_sum_q <= line_sum_d;
        total_q    <= total_d;
        zero_q     <= zero_d;
      end
    end
  end

  // ------------------------------------------------------------ result queue
  mtlm_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (head)
  );

  assign result_kind_o   = head.kind;
  assign line_number_o   = head.line_number;
  assign match_count_o   = head.match_count;
  assign saw_zero_byte_o = head.saw_zero;
  assign last_of_run_o   = head.last;

  // -------------------------------------------------------------- checks
  // a summary always closes the run of its byte
  `ASSERT_CLK(a_summary_is_last,
    out_valid_o && (result_kind_o == mtlm_pkg::KIND_SUMMARY) |-> last_of_run_o)
  // the final byte of a file always produces its summary
  `ASSERT_CLK(a_end_pushes, step && end_q |-> push.cnt != 2'd0)
  // file counters restart after the final byte
  `ASSERT_CLK(a_file_cleared, step && end_q |=> (line_q == '0) && (total_q == '0))
  // two results only when a line report precedes the summary
  `ASSERT_NEVER_CLK(a_two_without_end, (push.cnt == 2'd2) && !end_q)

endmodule

`default_nettype wire
